// File: rtl/pir_pkg.sv
`default_nettype none

package pir_pkg;

    localparam int LINE_W            = 5;
    localparam int LEVEL_W           = 5;
    localparam int WORD_W            = 32;
    localparam int DEFAULT_NUM_LINES = 32;
    localparam int DEFAULT_Q_DEPTH   = 2;
    localparam int RESET_SWITCH_BIT  = 16;

    localparam logic [LEVEL_W-1:0] LOWEST_SEARCH = LEVEL_W'(2);
    localparam logic [LEVEL_W-1:0] CLOCK_LEVEL   = LEVEL_W'(28);

    localparam logic [LEVEL_W-1:0] LINE_LEVEL [WORD_W] = '{
        5'd28, 5'd23, 5'd15, 5'd15, 5'd14, 5'd18, 5'd18, 5'd24,
        5'd22, 5'd20, 5'd20, 5'd16, 5'd25, 5'd19, 5'd21, 5'd13,
        5'd13, 5'd16, 5'd16, 5'd16, 5'd29, 5'd29, 5'd29, 5'd20,
        5'd21, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

    typedef enum logic [1:0] {
        OP_ENABLE   = 2'd0,
        OP_DISABLE  = 2'd1,
        OP_SERVICE  = 2'd2,
        OP_COMPLETE = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [LINE_W-1:0] line;
        logic              line_ok;
        logic [WORD_W-1:0] cause;
    } cmd_t;

    typedef struct packed {
        logic               spurious;
        logic [LINE_W-1:0]  served_line;
        logic [LEVEL_W-1:0] level;
        logic [WORD_W-1:0]  mask;
        logic [WORD_W-1:0]  ack;
        logic               allow_lower;
    } result_t;

    function automatic logic [LINE_W-1:0] msb_index(input logic [WORD_W-1:0] v);
        logic [LINE_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
            begin
                r = LINE_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pir_fifo.sv
`default_nettype none

module pir_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pir_front.sv
`default_nettype none

module pir_front #(
    parameter int NUM_LINES = pir_pkg::DEFAULT_NUM_LINES
) (
    input  wire logic [1:0]                  opcode,
    input  wire logic [pir_pkg::LINE_W-1:0]  line,
    input  wire logic [pir_pkg::WORD_W-1:0]  cause_word,
    output pir_pkg::cmd_t                    cmd
);

    import pir_pkg::*;

    always_comb
    begin
        cmd.op      = op_t'(opcode);
        cmd.line    = line;
        cmd.line_ok = (WORD_W'(line) < WORD_W'(NUM_LINES));
        cmd.cause   = cause_word & ~(WORD_W'(1) << RESET_SWITCH_BIT);
    end

endmodule

`default_nettype wire

// File: rtl/pir_back.sv
`default_nettype none

module pir_back #(
    parameter int NUM_LINES = pir_pkg::DEFAULT_NUM_LINES
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire pir_pkg::cmd_t cmd,
    output pir_pkg::result_t   res
);

    import pir_pkg::*;

    logic [NUM_LINES-1:0] registered_set_reg, registered_set_next;
    logic [NUM_LINES-1:0] hw_mask_reg, hw_mask_next;
    logic [NUM_LINES-1:0] saved_mask_reg, saved_mask_next;
    logic [LEVEL_W-1:0]   current_level_reg, current_level_next;
    logic [LEVEL_W-1:0]   saved_level_reg, saved_level_next;
    logic [LINE_W-1:0]    active_line_reg, active_line_next;
    logic                 line_was_reg_reg, line_was_reg_next;

    logic [NUM_LINES-1:0] line_bit;
    logic [NUM_LINES-1:0] masked;
    logic [WORD_W-1:0]    level_hit;
    logic [LEVEL_W-1:0]   top_level;
    logic [LEVEL_W-1:0]   search_level;
    logic [NUM_LINES-1:0] level_mask;
    logic [NUM_LINES-1:0] sel;
    logic [LINE_W-1:0]    pick;
    logic [NUM_LINES-1:0] pick_bit;

    // The search level sits one below the highest pending level, but never below LOWEST_SEARCH.
    always_comb
    begin
        line_bit  = cmd.line_ok ? (NUM_LINES'(1) << cmd.line) : '0;
        masked    = cmd.cause[NUM_LINES-1:0] & hw_mask_reg;
        level_hit = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (masked[i])
            begin
                level_hit[LINE_LEVEL[i]] = 1'b1;
            end
        end
        top_level    = msb_index(level_hit);
        search_level = (top_level > LOWEST_SEARCH + LEVEL_W'(1)) ? top_level - LEVEL_W'(1)
                                                                 : LOWEST_SEARCH;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            level_mask[i] = (LINE_LEVEL[i] > search_level);
        end
        sel      = masked & level_mask;
        pick     = msb_index(WORD_W'(sel));
        pick_bit = NUM_LINES'(1) << pick;
    end

    always_comb
    begin
        registered_set_next = registered_set_reg;
        hw_mask_next        = hw_mask_reg;
        saved_mask_next     = saved_mask_reg;
        current_level_next  = current_level_reg;
        saved_level_next    = saved_level_reg;
        active_line_next    = active_line_reg;
        line_was_reg_next   = line_was_reg_reg;
        res.spurious        = 1'b0;
        res.served_line     = '0;
        res.ack             = '0;
        res.allow_lower     = 1'b0;
        case (cmd.op)
            OP_ENABLE:
            begin
                registered_set_next = registered_set_reg | line_bit;
                hw_mask_next        = hw_mask_reg | line_bit;
            end
            OP_DISABLE:
            begin
                registered_set_next = registered_set_reg & ~line_bit;
                hw_mask_next        = hw_mask_reg & ~line_bit;
            end
            OP_SERVICE:
            begin
                if (sel == '0)
                begin
                    res.spurious = 1'b1;
                end
                else
                begin
                    saved_mask_next     = hw_mask_reg;
                    saved_level_next    = current_level_reg;
                    active_line_next    = pick;
                    line_was_reg_next   = |(registered_set_reg & pick_bit);
                    registered_set_next = registered_set_reg & ~pick_bit;
                    hw_mask_next        = level_mask & registered_set_next;
                    current_level_next  = LINE_LEVEL[pick];
                    res.served_line     = pick;
                    res.ack             = WORD_W'(1) << pick;
                    res.allow_lower     = (search_level < CLOCK_LEVEL);
                end
            end
            OP_COMPLETE:
            begin
                if (line_was_reg_reg)
                begin
                    registered_set_next = registered_set_reg
                                        | (NUM_LINES'(1) << active_line_reg);
                end
                line_was_reg_next  = 1'b0;
                current_level_next = saved_level_reg;
                hw_mask_next       = saved_mask_reg;
                res.served_line    = active_line_reg;
            end
            default:
            begin
                res.spurious = 1'b0;
            end
        endcase
        res.level = current_level_next;
        res.mask  = WORD_W'(hw_mask_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            registered_set_reg <= '0;
            hw_mask_reg        <= '0;
            saved_mask_reg     <= '0;
            current_level_reg  <= '0;
            saved_level_reg    <= '0;
            active_line_reg    <= '0;
            line_was_reg_reg   <= 1'b0;
        end
        else if (fire)
        begin
            registered_set_reg <= registered_set_next;
            hw_mask_reg        <= hw_mask_next;
            saved_mask_reg     <= saved_mask_next;
            current_level_reg  <= current_level_next;
            saved_level_reg    <= saved_level_next;
            active_line_reg    <= active_line_next;
            line_was_reg_reg   <= line_was_reg_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/priority_interrupt_resolver_core.sv
// Channel   Direction  Handshake        Beat contents
// input     in         push / full      opcode, line, cause_word
// result    out        empty / pop      spurious, served_line_out, new_level,
//                                       mask_write, ack_write, allow_lower
//
// One beat is accepted per cycle while full is low; a result beat passes through the
// command queue and the result queue before it reaches the result ports.
// Only a full result queue stalls intake; the pir_back search is combinational.
// Reset clears all interrupt state and both queues; nothing needs a clearing pass.
// A stalled result queue fills the command queue, after which full rises.
`default_nettype none

module priority_interrupt_resolver_core #(
    parameter int NUM_LINES = pir_pkg::DEFAULT_NUM_LINES,
    parameter int Q_DEPTH   = pir_pkg::DEFAULT_Q_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  opcode,
    input  wire logic [pir_pkg::LINE_W-1:0]  line,
    input  wire logic [pir_pkg::WORD_W-1:0]  cause_word,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             spurious,
    output logic [pir_pkg::LINE_W-1:0]       served_line_out,
    output logic [pir_pkg::LEVEL_W-1:0]      new_level,
    output logic [pir_pkg::WORD_W-1:0]      mask_write,
    output logic [pir_pkg::WORD_W-1:0]      ack_write,
    output logic                             allow_lower
);

    import pir_pkg::*;

    cmd_t    front_cmd, back_cmd;
    result_t back_res, out_res;
    logic    cmdq_empty, resq_full, fire;
    logic [$bits(cmd_t)-1:0]    cmdq_rdata;
    logic [$bits(result_t)-1:0] resq_rdata;

    pir_front #(.NUM_LINES(NUM_LINES)) u_front (
        .opcode     (opcode),
        .line       (line),
        .cause_word (cause_word),
        .cmd        (front_cmd)
    );

    pir_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(Q_DEPTH)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (fire),
        .empty (cmdq_empty),
        .rdata (cmdq_rdata)
    );

    assign back_cmd = cmd_t'(cmdq_rdata);
    assign fire     = !cmdq_empty && !resq_full;

    pir_back #(.NUM_LINES(NUM_LINES)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (back_cmd),
        .res   (back_res)
    );

    pir_fifo #(.WIDTH($bits(result_t)), .DEPTH(Q_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .wdata (back_res),
        .full  (resq_full),
        .pop   (pop),
        .empty (empty),
        .rdata (resq_rdata)
    );

    assign out_res         = result_t'(resq_rdata);
    assign spurious        = out_res.spurious;
    assign served_line_out = out_res.served_line;
    assign new_level       = out_res.level;
    assign mask_write      = out_res.mask;
    assign ack_write       = out_res.ack;
    assign allow_lower     = out_res.allow_lower;

endmodule

`default_nettype wire

// File: rtl/pir_checker.sv
`default_nettype none

module pir_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic                        spurious,
    input wire logic [pir_pkg::LINE_W-1:0]  served_line_out,
    input wire logic [pir_pkg::LEVEL_W-1:0] new_level,
    input wire logic [pir_pkg::WORD_W-1:0]  mask_write,
    input wire logic [pir_pkg::WORD_W-1:0]  ack_write,
    input wire logic                        allow_lower
);

    import pir_pkg::*;

    a_ack_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot0(ack_write))
        else $error("ack_write has more than one bit set");

    a_ack_matches_line: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ack_write != '0) |->
            (ack_write == (WORD_W'(1) << served_line_out)) && !spurious)
        else $error("ack_write does not match the served line");

    a_spurious_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && spurious) |-> (ack_write == '0) && !allow_lower)
        else $error("spurious beat carries an acknowledge");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(mask_write) && $stable(new_level)
            && $stable(ack_write) && $stable(served_line_out))
        else $error("stalled result beat changed");

endmodule

bind priority_interrupt_resolver_core pir_checker u_pir_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import pir_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int RANDOM_BEATS = 1850;
    localparam int SWITCH_BIT = 16;
    localparam int TOP_LVL = 31;
    localparam int FLOOR_LVL = 2;
    localparam int CLOCK_LVL = 28;

    localparam logic [4:0] LEVEL_OF [32] = '{
        5'd28, 5'd23, 5'd15, 5'd15, 5'd14, 5'd18, 5'd18, 5'd24,
        5'd22, 5'd20, 5'd20, 5'd16, 5'd25, 5'd19, 5'd21, 5'd13,
        5'd13, 5'd16, 5'd16, 5'd16, 5'd29, 5'd29, 5'd29, 5'd20,
        5'd21, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  opcode = '0;
    logic [4:0]  line = '0;
    logic [31:0] cause_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        spurious;
    logic [4:0]  served_line_out;
    logic [4:0]  new_level;
    logic [31:0] mask_write;
    logic [31:0] ack_write;
    logic        allow_lower;

    // Predicted interrupt state.
    logic [31:0] reg_set = '0;
    logic [31:0] hmask = '0;
    logic [4:0]  cur_lvl = '0;
    logic [4:0]  sv_lvl = '0;
    logic [31:0] sv_mask = '0;
    logic [4:0]  act_line = '0;
    logic        act_was_reg = 1'b0;

    result_t     pending_results[$];
    int          mismatch_count = 0;
    int          beats_sent = 0;
    int          burst_left = 0;
    int          pop_pct = 100;
    int          pop_phase = 0;

    priority_interrupt_resolver_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .opcode(opcode),
        .line(line),
        .cause_word(cause_word),
        .empty(empty),
        .pop(pop),
        .spurious(spurious),
        .served_line_out(served_line_out),
        .new_level(new_level),
        .mask_write(mask_write),
        .ack_write(ack_write),
        .allow_lower(allow_lower)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [31:0] levels_over(int lvl);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (int'(LEVEL_OF[i]) > lvl)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic result_t resolve_beat(op_t op, logic [4:0] ln, logic [31:0] cw);
        result_t     r;
        logic [31:0] pend;
        logic [31:0] lm;
        int          lvl;
        int          pick;
        r = '0;
        case (op)
            OP_ENABLE:
            begin
                reg_set[ln] = 1'b1;
                hmask[ln] = 1'b1;
            end
            OP_DISABLE:
            begin
                reg_set[ln] = 1'b0;
                hmask[ln] = 1'b0;
            end
            OP_SERVICE:
            begin
                pend = cw & hmask;
                pend[SWITCH_BIT] = 1'b0;
                lvl = TOP_LVL;
                while (lvl > FLOOR_LVL && (levels_over(lvl) & pend) == '0)
                begin
                    lvl--;
                end
                lm = levels_over(lvl);
                pend = pend & lm;
                if (pend == '0)
                begin
                    r.spurious = 1'b1;
                end
                else
                begin
                    pick = 31;
                    while (!pend[pick])
                    begin
                        pick--;
                    end
                    sv_mask = hmask;
                    sv_lvl = cur_lvl;
                    act_line = 5'(pick);
                    act_was_reg = reg_set[pick];
                    reg_set[pick] = 1'b0;
                    hmask = lm & reg_set;
                    cur_lvl = LEVEL_OF[pick];
                    r.served_line = 5'(pick);
                    r.ack = 32'd1 << pick;
                    r.allow_lower = (lvl < CLOCK_LVL);
                end
            end
            default:
            begin
                if (act_was_reg)
                begin
                    reg_set[act_line] = 1'b1;
                end
                act_was_reg = 1'b0;
                cur_lvl = sv_lvl;
                hmask = sv_mask;
                r.served_line = act_line;
            end
        endcase
        r.level = cur_lvl;
        r.mask = hmask;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got 0x%08h, expected 0x%08h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sends one beat (after an idle gap when a burst runs out); returns at the accepting edge.
    task automatic send_beat(op_t op, logic [4:0] ln, logic [31:0] cw);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        push <= 1'b1;
        opcode <= op;
        line <= ln;
        cause_word <= cw;
        do
        begin
            @(posedge clk);
        end
        while (full);
        pending_results.push_back(resolve_beat(op, ln, cw));
        beats_sent++;
        burst_left--;
    endtask

    function automatic logic [31:0] random_cause();
        logic [31:0] cw;
        case ($urandom_range(0, 6))
            0: cw = $urandom;
            1: cw = 32'd1 << $urandom_range(0, 31);
            2: cw = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31))
                    | (32'd1 << $urandom_range(0, 24));
            3: cw = hmask & $urandom;
            4: cw = ($urandom & 32'hFE00_0000) | (32'($urandom_range(0, 1)) << SWITCH_BIT);
            5: cw = ($urandom_range(0, 1) == 0) ? 32'd0 : (32'd1 << SWITCH_BIT);
            default: cw = $urandom & $urandom & $urandom;
        endcase
        return cw;
    endfunction

    task automatic test_after_reset();
        send_beat(OP_COMPLETE, 5'd0, 32'd0);
        send_beat(OP_SERVICE, 5'd31, 32'hFFFF_FFFF);
    endtask

    task automatic test_line_control();
        send_beat(OP_ENABLE, 5'd0, 32'd0);
        send_beat(OP_ENABLE, 5'd16, 32'd0);
        send_beat(OP_ENABLE, 5'd22, 32'd0);
        send_beat(OP_ENABLE, 5'd25, 32'd0);
        send_beat(OP_ENABLE, 5'd31, 32'hFFFF_FFFF);
        send_beat(OP_ENABLE, 5'd2, 32'd0);
        send_beat(OP_ENABLE, 5'd15, 32'd0);
    endtask

    task automatic test_service_cases();
        // Highest level wins, then a nested service finds nothing above it.
        send_beat(OP_SERVICE, 5'd0, 32'hFFFF_FFFF);
        send_beat(OP_SERVICE, 5'd0, 32'hFFFF_FFFF);
        send_beat(OP_COMPLETE, 5'd0, 32'd0);
        send_beat(OP_COMPLETE, 5'd0, 32'd0);
        // The reset switch bit alone and level-zero lines alone are spurious.
        send_beat(OP_SERVICE, 5'd0, 32'd1 << SWITCH_BIT);
        send_beat(OP_SERVICE, 5'd0, 32'h8200_0000);
        // The lowest level opens every higher level.
        send_beat(OP_SERVICE, 5'd0, 32'd1 << 15);
        send_beat(OP_COMPLETE, 5'd0, 32'd0);
        send_beat(OP_DISABLE, 5'd22, 32'd0);
        send_beat(OP_DISABLE, 5'd31, 32'd0);
        send_beat(OP_SERVICE, 5'd0, 32'hFFFF_FFFF);
        send_beat(OP_COMPLETE, 5'd0, 32'd0);
    endtask

    task automatic test_random_traffic();
        int target;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_beat(OP_ENABLE, 5'($urandom_range(0, 31)), $urandom);
                3: send_beat(OP_DISABLE, 5'($urandom_range(0, 31)), $urandom);
                4, 5, 6, 7:
                begin
                    send_beat(OP_SERVICE, 5'($urandom_range(0, 31)), random_cause());
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_beat(OP_SERVICE, 5'($urandom_range(0, 31)), random_cause());
                    end
                    send_beat(OP_COMPLETE, 5'($urandom_range(0, 31)), $urandom);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_beat(OP_COMPLETE, 5'($urandom_range(0, 31)), $urandom);
                    end
                end
                8: send_beat(op_t'($urandom_range(2, 3)), 5'($urandom_range(0, 31)),
                             random_cause());
                default: send_beat(op_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                                   $urandom);
            endcase
        end
    endtask

    // Result side: check each popped beat, then pick the next pop on a shifting stall rate.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (spurious !== want.spurious)
                    report_mismatch("spurious", 32'(spurious), 32'(want.spurious));
                if (served_line_out !== want.served_line)
                    report_mismatch("served_line_out", 32'(served_line_out),
                                    32'(want.served_line));
                if (new_level !== want.level)
                    report_mismatch("new_level", 32'(new_level), 32'(want.level));
                if (mask_write !== want.mask)
                    report_mismatch("mask_write", mask_write, want.mask);
                if (ack_write !== want.ack)
                    report_mismatch("ack_write", ack_write, want.ack);
                if (allow_lower !== want.allow_lower)
                    report_mismatch("allow_lower", 32'(allow_lower), 32'(want.allow_lower));
            end
        end
        pop_phase++;
        if (pop_phase >= 128)
        begin
            pop_phase = 0;
            case ($urandom_range(0, 4))
                0, 1: pop_pct = 100;
                2: pop_pct = 70;
                3: pop_pct = 30;
                default: pop_pct = 5;
            endcase
        end
        pop <= rst_n && ($urandom_range(0, 99) < pop_pct);
    end

    initial
    begin
        #2_000_000;
        $display("priority_interrupt_resolver_core regression: fail");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_line_control();
        test_service_cases();
        test_random_traffic();
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("priority_interrupt_resolver_core regression: pass");
        end
        else
        begin
            $display("priority_interrupt_resolver_core regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pir_pkg.sv
rtl/pir_fifo.sv
rtl/pir_front.sv
rtl/pir_back.sv
rtl/priority_interrupt_resolver_core.sv
rtl/pir_checker.sv
tb/sv/tb_top.sv
